// ----- rtl/itrk_pkg.sv -----
// Shared types, widths and codes for the IoU box tracker.
`default_nettype none

package itrk_pkg;

    localparam int COORD_W        = 12;
    localparam int AREA_W         = 2 * COORD_W;
    localparam int UNION_W        = AREA_W + 1;
    localparam int XPROD_W        = AREA_W + UNION_W;
    localparam int ID_W           = 16;
    localparam int TIME_W         = 32;
    localparam int AGE_W          = 16;
    localparam int THR_W          = 8;
    localparam int KIND_W         = 3;
    localparam int FUNC_W         = 2;
    localparam int S_DATA_W       = 80;
    localparam int M_DATA_W       = 64;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 16;
    localparam int MAX_TRACKS_DEF = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int RES_CNT_W      = $clog2(MAX_RESULTS);

    localparam logic [AGE_W-1:0] MAX_AGE_RST = 16'd3000;
    localparam logic [THR_W-1:0] IOU_THR_RST = 8'd90;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IOU_THR = 8'd1;

    // Request operations
    localparam logic [FUNC_W-1:0] OP_BEGIN  = 2'd0;
    localparam logic [FUNC_W-1:0] OP_DETECT = 2'd1;
    localparam logic [FUNC_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [FUNC_W-1:0] OP_REPORT = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ACK       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MATCHED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NEW       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DROPPED   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ENTRY     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NO_TRACKS = 3'd5;

    typedef struct packed {
        logic [COORD_W-1:0] h;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } box_t;

    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic [TIME_W-1:0] time_ms;
        box_t              box;
        logic [AREA_W-1:0] area;
    } item_t;

    typedef struct packed {
        logic [AGE_W-1:0] max_age_ms;
        logic [THR_W-1:0] iou_thr;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   track_id;
        box_t              box;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/itrk_front.sv -----
// Request intake: decode, detection area, two-entry queue toward the engine.
`default_nettype none

module itrk_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // time_ms[31:0], box_x[43:32], box_y[55:44], box_w[67:56], box_h[79:68]
    input  wire logic [itrk_pkg::S_DATA_W-1:0]   s_tdata,
    // func[1:0]
    input  wire logic [itrk_pkg::FUNC_W-1:0]     s_tuser,
    output logic                                 q_valid,
    input  wire logic                            q_ready,
    output itrk_pkg::item_t                      q_item
);
    import itrk_pkg::*;

    item_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    item_t       in_item;
    logic        push;
    logic        pop;

    always_comb begin
        in_item.op      = s_tuser;
        in_item.time_ms = s_tdata[31:0];
        in_item.box.x   = s_tdata[43:32];
        in_item.box.y   = s_tdata[55:44];
        in_item.box.w   = s_tdata[67:56];
        in_item.box.h   = s_tdata[79:68];
        in_item.area    = s_tdata[67:56] * s_tdata[79:68];
    end

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/itrk_back.sv -----
// Track table engine: aging, greedy IoU matching, track creation and listing.
`default_nettype none

module itrk_back #(
    parameter int MAX_TRACKS = itrk_pkg::MAX_TRACKS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    output logic                   q_ready,
    input  wire itrk_pkg::item_t   q_item,
    input  wire itrk_pkg::cfg_t    cfg,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output itrk_pkg::result_t      m_result
);
    import itrk_pkg::*;

    localparam int SLOT_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_TRACKS - 1);
    localparam logic [RES_CNT_W-1:0] LAST_RES = RES_CNT_W'(MAX_RESULTS - 1);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_AGE_RD    = 4'd1;
    localparam logic [3:0] ST_AGE_CHK   = 4'd2;
    localparam logic [3:0] ST_ACK       = 4'd3;
    localparam logic [3:0] ST_EMPTY     = 4'd4;
    localparam logic [3:0] ST_REP_RD    = 4'd5;
    localparam logic [3:0] ST_REP_EMIT  = 4'd6;
    localparam logic [3:0] ST_DET_RD    = 4'd7;
    localparam logic [3:0] ST_DET_OVL   = 4'd8;
    localparam logic [3:0] ST_DET_MUL   = 4'd9;
    localparam logic [3:0] ST_DET_UNI   = 4'd10;
    localparam logic [3:0] ST_DET_XM1   = 4'd11;
    localparam logic [3:0] ST_DET_XM2   = 4'd12;
    localparam logic [3:0] ST_DET_CMP   = 4'd13;
    localparam logic [3:0] ST_DET_THR   = 4'd14;
    localparam logic [3:0] ST_DET_WRITE = 4'd15;

    // Track store
    logic [ID_W-1:0]    id_mem   [MAX_TRACKS];
    box_t               box_mem  [MAX_TRACKS];
    logic [TIME_W-1:0]  seen_mem [MAX_TRACKS];
    logic [ID_W-1:0]    rd_id_reg;
    box_t               rd_box_reg;
    logic [TIME_W-1:0]  rd_seen_reg;

    logic [MAX_TRACKS-1:0] valid_reg;
    logic [MAX_TRACKS-1:0] used_reg;
    logic [ID_W-1:0]       id_counter_reg;
    logic [TIME_W-1:0]     frame_time_reg;

    logic [3:0]            state_reg;
    item_t                 item_reg;
    logic [SLOT_W-1:0]     scan_reg;
    logic [RES_CNT_W-1:0]  cnt_reg;
    logic [SLOT_W-1:0]     best_reg;
    logic                  best_ok_reg;
    logic                  match_reg;
    logic [AREA_W-1:0]     bi_reg;
    logic [UNION_W-1:0]    bu_reg;
    logic [COORD_W-1:0]    iw_reg;
    logic [COORD_W-1:0]    ih_reg;
    logic [AREA_W-1:0]     tarea_reg;
    logic [AREA_W-1:0]     inter_reg;
    logic [UNION_W-1:0]    uni_reg;
    logic [XPROD_W-1:0]    lhs_reg;
    logic [XPROD_W-1:0]    rhs_reg;

    logic                  m_valid_reg;
    result_t               m_result_reg;

    logic                  can_emit;
    logic                  last_slot;
    logic                  above;
    logic                  free_ok;
    logic [SLOT_W-1:0]     free_idx;
    logic [COORD_W:0]      iw_calc;
    logic [COORD_W:0]      ih_calc;
    logic                  thr_pass;
    logic                  take;
    logic                  wr_en;
    logic                  wr_id_en;
    logic [SLOT_W-1:0]     wr_addr;

    function automatic logic [COORD_W:0] overlap(
        input logic [COORD_W-1:0] a0, input logic [COORD_W-1:0] al,
        input logic [COORD_W-1:0] b0, input logic [COORD_W-1:0] bl);
        logic [COORD_W:0] lo;
        logic [COORD_W:0] ea;
        logic [COORD_W:0] eb;
        logic [COORD_W:0] hi;
        lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
        ea = {1'b0, a0} + {1'b0, al};
        eb = {1'b0, b0} + {1'b0, bl};
        hi = (ea < eb) ? ea : eb;
        return (hi > lo) ? (hi - lo) : '0;
    endfunction

    assign can_emit  = !m_valid_reg || m_ready;
    assign last_slot = (scan_reg == LAST_SLOT);
    assign q_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_result  = m_result_reg;
    assign take      = (uni_reg != '0) && (lhs_reg > rhs_reg);

    always_comb begin
        above = 1'b0;
        for (int i = 0; i < MAX_TRACKS; i++) begin
            if (valid_reg[i] && (i > int'(scan_reg))) begin
                above = 1'b1;
            end
        end
    end

    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_ok  = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        iw_calc  = overlap(item_reg.box.x, item_reg.box.w, rd_box_reg.x, rd_box_reg.w);
        ih_calc  = overlap(item_reg.box.y, item_reg.box.h, rd_box_reg.y, rd_box_reg.h);
        thr_pass = ({1'b0, bi_reg, 8'd0} >= (cfg.iou_thr * {8'd0, bu_reg}));
    end

    always_comb begin
        wr_en    = 1'b0;
        wr_id_en = 1'b0;
        wr_addr  = best_reg;
        if (state_reg == ST_DET_WRITE && can_emit) begin
            if (match_reg) begin
                wr_en = 1'b1;
            end else if (free_ok) begin
                wr_en    = 1'b1;
                wr_id_en = 1'b1;
                wr_addr  = free_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_id_reg   <= id_mem[scan_reg];
        rd_box_reg  <= box_mem[scan_reg];
        rd_seen_reg <= seen_mem[scan_reg];
        if (wr_en) begin
            box_mem[wr_addr]  <= item_reg.box;
            seen_mem[wr_addr] <= frame_time_reg;
        end
        if (wr_id_en) begin
            id_mem[wr_addr] <= id_counter_reg;
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid) begin
            item_reg <= q_item;
        end
        if (state_reg == ST_DET_OVL) begin
            iw_reg    <= iw_calc[COORD_W-1:0];
            ih_reg    <= ih_calc[COORD_W-1:0];
            tarea_reg <= rd_box_reg.w * rd_box_reg.h;
        end
        if (state_reg == ST_DET_MUL) begin
            inter_reg <= iw_reg * ih_reg;
        end
        if (state_reg == ST_DET_UNI) begin
            uni_reg <= {1'b0, item_reg.area} + {1'b0, tarea_reg} - {1'b0, inter_reg};
        end
        if (state_reg == ST_DET_XM1) begin
            lhs_reg <= inter_reg * bu_reg;
        end
        if (state_reg == ST_DET_XM2) begin
            rhs_reg <= bi_reg * uni_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            used_reg       <= '0;
            id_counter_reg <= '0;
            frame_time_reg <= '0;
            scan_reg       <= '0;
            cnt_reg        <= '0;
            best_reg       <= '0;
            best_ok_reg    <= 1'b0;
            match_reg      <= 1'b0;
            bi_reg         <= '0;
            bu_reg         <= UNION_W'(1);
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        scan_reg    <= '0;
                        cnt_reg     <= '0;
                        best_ok_reg <= 1'b0;
                        bi_reg      <= '0;
                        bu_reg      <= UNION_W'(1);
                        unique case (q_item.op)
                            OP_BEGIN: begin
                                frame_time_reg <= q_item.time_ms;
                                used_reg       <= '0;
                                state_reg      <= ST_AGE_RD;
                            end
                            OP_CLEAR: begin
                                valid_reg      <= '0;
                                used_reg       <= '0;
                                id_counter_reg <= '0;
                                state_reg      <= ST_ACK;
                            end
                            OP_REPORT: begin
                                state_reg <= (valid_reg == '0) ? ST_EMPTY : ST_REP_RD;
                            end
                            OP_DETECT: begin
                                state_reg <= ST_DET_RD;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_AGE_RD: begin
                    if (valid_reg[scan_reg]) begin
                        state_reg <= ST_AGE_CHK;
                    end else if (last_slot) begin
                        state_reg <= ST_ACK;
                    end else begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                ST_AGE_CHK: begin
                    // drop tracks not seen within the age limit
                    if ((frame_time_reg - rd_seen_reg) > {16'd0, cfg.max_age_ms}) begin
                        valid_reg[scan_reg] <= 1'b0;
                    end
                    if (last_slot) begin
                        state_reg <= ST_ACK;
                    end else begin
                        scan_reg  <= scan_reg + 1'b1;
                        state_reg <= ST_AGE_RD;
                    end
                end
                ST_ACK, ST_EMPTY: begin
                    if (can_emit) begin
                        m_valid_reg           <= 1'b1;
                        m_result_reg.kind     <= (state_reg == ST_ACK) ? KIND_ACK
                                                                       : KIND_NO_TRACKS;
                        m_result_reg.track_id <= '0;
                        m_result_reg.box      <= '0;
                        m_result_reg.last     <= 1'b1;
                        state_reg             <= ST_IDLE;
                    end
                end
                ST_REP_RD: begin
                    if (valid_reg[scan_reg]) begin
                        state_reg <= ST_REP_EMIT;
                    end else if (last_slot) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                ST_REP_EMIT: begin
                    if (can_emit) begin
                        m_valid_reg           <= 1'b1;
                        m_result_reg.kind     <= KIND_ENTRY;
                        m_result_reg.track_id <= rd_id_reg;
                        m_result_reg.box      <= rd_box_reg;
                        m_result_reg.last     <= (cnt_reg == LAST_RES) || !above;
                        if ((cnt_reg == LAST_RES) || !above) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            cnt_reg   <= cnt_reg + 1'b1;
                            scan_reg  <= scan_reg + 1'b1;
                            state_reg <= ST_REP_RD;
                        end
                    end
                end
                ST_DET_RD: begin
                    if (valid_reg[scan_reg] && !used_reg[scan_reg]) begin
                        state_reg <= ST_DET_OVL;
                    end else if (last_slot) begin
                        // point the read port at the winner so its id is ready
                        scan_reg  <= best_reg;
                        state_reg <= ST_DET_THR;
                    end else begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                ST_DET_OVL: state_reg <= ST_DET_MUL;
                ST_DET_MUL: state_reg <= ST_DET_UNI;
                ST_DET_UNI: state_reg <= ST_DET_XM1;
                ST_DET_XM1: state_reg <= ST_DET_XM2;
                ST_DET_XM2: state_reg <= ST_DET_CMP;
                ST_DET_CMP: begin
                    // keep the first slot on a tie
                    if (take) begin
                        bi_reg      <= inter_reg;
                        bu_reg      <= uni_reg;
                        best_reg    <= scan_reg;
                        best_ok_reg <= 1'b1;
                    end
                    if (last_slot) begin
                        // point the read port at the winner so its id is ready
                        if (!take) begin
                            scan_reg <= best_reg;
                        end
                        state_reg <= ST_DET_THR;
                    end else begin
                        scan_reg  <= scan_reg + 1'b1;
                        state_reg <= ST_DET_RD;
                    end
                end
                ST_DET_THR: begin
                    match_reg <= best_ok_reg && thr_pass;
                    state_reg <= ST_DET_WRITE;
                end
                ST_DET_WRITE: begin
                    if (can_emit) begin
                        m_valid_reg       <= 1'b1;
                        m_result_reg.box  <= item_reg.box;
                        m_result_reg.last <= 1'b1;
                        if (match_reg) begin
                            used_reg[best_reg]    <= 1'b1;
                            m_result_reg.kind     <= KIND_MATCHED;
                            m_result_reg.track_id <= rd_id_reg;
                        end else if (free_ok) begin
                            valid_reg[free_idx]   <= 1'b1;
                            used_reg[free_idx]    <= 1'b1;
                            id_counter_reg        <= id_counter_reg + 1'b1;
                            m_result_reg.kind     <= KIND_NEW;
                            m_result_reg.track_id <= id_counter_reg;
                        end else begin
                            m_result_reg.kind     <= KIND_DROPPED;
                            m_result_reg.track_id <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/iou_greedy_box_tracker.sv -----
// Per request: begin frame scans all slots, ages out stale tracks, acks; clear acks; empty
// report sends a no-tracks result; report walks slots up to the last listed track, one entry
// each. Detection skips free and used slots and runs each candidate through store read,
// overlap, intersection, union, two cross products and compare, then decides and writes
// back. One request is worked at a time, two more wait; a held result stalls the engine.
// Reset (aresetn low, synchronous) empties table and queue, zeroes id counter and frame time.
`default_nettype none

module iou_greedy_box_tracker #(
    parameter int MAX_TRACKS = itrk_pkg::MAX_TRACKS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // time_ms[31:0], box_x[43:32], box_y[55:44], box_w[67:56], box_h[79:68]
    input  wire logic [itrk_pkg::S_DATA_W-1:0]     s_tdata,
    // func[1:0]
    input  wire logic [itrk_pkg::FUNC_W-1:0]       s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // track_id[15:0], out_x[27:16], out_y[39:28], out_w[51:40], out_h[63:52]
    output logic [itrk_pkg::M_DATA_W-1:0]          m_tdata,
    // kind[2:0]
    output logic [itrk_pkg::KIND_W-1:0]            m_tuser,
    output logic                                   m_tlast,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [itrk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [itrk_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import itrk_pkg::*;

    logic              q_valid;
    logic              q_ready;
    item_t             q_item;
    cfg_t              cfg_reg;
    result_t           result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_age_ms <= MAX_AGE_RST;
            cfg_reg.iou_thr    <= IOU_THR_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_MAX_AGE) begin
                cfg_reg.max_age_ms <= cfg_data;
            end
            if (cfg_index == REG_IOU_THR) begin
                cfg_reg.iou_thr <= cfg_data[THR_W-1:0];
            end
        end
    end

    itrk_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    itrk_back #(
        .MAX_TRACKS (MAX_TRACKS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .cfg      (cfg_reg),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    assign m_tdata = {result.box.h, result.box.w, result.box.y, result.box.x, result.track_id};
    assign m_tuser = result.kind;
    assign m_tlast = result.last;

`ifndef SYNTH
    a_ack_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_ACK)) |-> (m_tlast && (m_tdata == '0)))
        else $error("ack result carries data or is not last");

    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_NO_TRACKS)) |-> (m_tlast && (m_tdata == '0)))
        else $error("empty report result malformed");

    a_drop_no_id: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_DROPPED)) |-> (m_tlast && (m_tdata[15:0] == '0)))
        else $error("dropped detection carries a track id");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_tracker_checker.sv -----
// Result checker for the IoU box tracker: watches requests, predicts results, compares.
`timescale 1ns / 1ps
`default_nettype none

module tb_tracker_checker
    import itrk_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    input  wire logic [FUNC_W-1:0]     s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [M_DATA_W-1:0]   m_tdata,
    input  wire logic [KIND_W-1:0]     m_tuser,
    input  wire logic                  m_tlast,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending_count,
    output int                         result_count,
    output int                         match_count,
    output int                         new_count,
    output int                         drop_count
);

    localparam int NSLOT = MAX_TRACKS_DEF;

    logic              trk_valid [NSLOT];
    logic              trk_used  [NSLOT];
    logic [ID_W-1:0]   trk_id    [NSLOT];
    box_t              trk_box   [NSLOT];
    logic [TIME_W-1:0] trk_seen  [NSLOT];
    logic [ID_W-1:0]   next_id;
    logic [TIME_W-1:0] cur_frame;
    logic [AGE_W-1:0]  age_limit;
    logic [THR_W-1:0]  iou_thr;

    result_t expected_results[$];

    assign pending_count = expected_results.size();

    function automatic logic [63:0] span_overlap(logic [11:0] a0, logic [11:0] al,
                                                 logic [11:0] b0, logic [11:0] bl);
        logic [31:0] lo, hi, ea, eb;
        lo = (a0 > b0) ? 32'(a0) : 32'(b0);
        ea = 32'(a0) + 32'(al);
        eb = 32'(b0) + 32'(bl);
        hi = (ea < eb) ? ea : eb;
        return (hi > lo) ? 64'(hi - lo) : 64'd0;
    endfunction

    function automatic result_t make_result(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
                                            box_t b, logic fin);
        result_t r;
        r.kind = k;
        r.track_id = id;
        r.box = b;
        r.last = fin;
        return r;
    endfunction

    // append to the tail of the expected queue
    task automatic add_expected(result_t r);
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic track_request(logic [FUNC_W-1:0] op, logic [S_DATA_W-1:0] d);
        box_t det;
        logic [63:0] bi, bu, i, u, iw, ih;
        int best, n, lastk;
        bit placed;
        det.x = d[43:32];
        det.y = d[55:44];
        det.w = d[67:56];
        det.h = d[79:68];
        case (op)
            OP_BEGIN: begin
                cur_frame = d[31:0];
                for (int s = 0; s < NSLOT; s++) begin
                    if (trk_valid[s] && (cur_frame - trk_seen[s]) > 32'(age_limit))
                        trk_valid[s] = 1'b0;
                    trk_used[s] = 1'b0;
                end
                add_expected(make_result(KIND_ACK, '0, '0, 1'b1));
            end
            OP_CLEAR: begin
                for (int s = 0; s < NSLOT; s++) begin
                    trk_valid[s] = 1'b0;
                    trk_used[s] = 1'b0;
                end
                next_id = '0;
                add_expected(make_result(KIND_ACK, '0, '0, 1'b1));
            end
            OP_REPORT: begin
                n = 0;
                lastk = -1;
                for (int s = 0; s < NSLOT; s++) begin
                    if (trk_valid[s] && n < MAX_RESULTS) begin
                        lastk = expected_results.size();
                        add_expected(make_result(KIND_ENTRY, trk_id[s], trk_box[s], 1'b0));
                        n++;
                    end
                end
                if (lastk < 0)
                    add_expected(make_result(KIND_NO_TRACKS, '0, '0, 1'b1));
                else
                    expected_results[lastk].last = 1'b1;
            end
            default: begin
                bi = 0;
                bu = 1;
                best = -1;
                for (int s = 0; s < NSLOT; s++) begin
                    if (trk_valid[s] && !trk_used[s]) begin
                        iw = span_overlap(det.x, det.w, trk_box[s].x, trk_box[s].w);
                        ih = span_overlap(det.y, det.h, trk_box[s].y, trk_box[s].h);
                        i = iw * ih;
                        u = 64'(det.w) * 64'(det.h) + 64'(trk_box[s].w) * 64'(trk_box[s].h) - i;
                        if (u != 0 && i * bu > bi * u) begin
                            bi = i;
                            bu = u;
                            best = s;
                        end
                    end
                end
                if (best >= 0 && bi * 256 >= 64'(iou_thr) * bu) begin
                    trk_box[best] = det;
                    trk_seen[best] = cur_frame;
                    trk_used[best] = 1'b1;
                    add_expected(make_result(KIND_MATCHED, trk_id[best], det, 1'b1));
                end else begin
                    placed = 0;
                    for (int s = 0; s < NSLOT; s++) begin
                        if (!placed && !trk_valid[s]) begin
                            placed = 1;
                            trk_valid[s] = 1'b1;
                            trk_used[s] = 1'b1;
                            trk_id[s] = next_id;
                            trk_box[s] = det;
                            trk_seen[s] = cur_frame;
                            add_expected(make_result(KIND_NEW, next_id, det, 1'b1));
                            next_id = next_id + 1'b1;
                        end
                    end
                    if (!placed)
                        add_expected(make_result(KIND_DROPPED, '0, det, 1'b1));
                end
            end
        endcase
    endtask

    task automatic compare_result();
        result_t exp_r;
        box_t act_box;
        if (expected_results.size() == 0) begin
            $error("unexpected result: kind %0d tdata %h", m_tuser, m_tdata);
            fail_count++;
            return;
        end
        exp_r = expected_results.pop_front();
        act_box.x = m_tdata[27:16];
        act_box.y = m_tdata[39:28];
        act_box.w = m_tdata[51:40];
        act_box.h = m_tdata[63:52];
        case (exp_r.kind)
            KIND_MATCHED: match_count++;
            KIND_NEW:     new_count++;
            KIND_DROPPED: drop_count++;
            default: ;
        endcase
        if (m_tuser !== exp_r.kind) begin
            $error("kind: expected %0d, got %0d", exp_r.kind, m_tuser);
            fail_count++;
        end
        if (m_tdata[15:0] !== exp_r.track_id) begin
            $error("track_id: expected %0d, got %0d", exp_r.track_id, m_tdata[15:0]);
            fail_count++;
        end
        if (act_box.x !== exp_r.box.x) begin
            $error("out_x: expected %0d, got %0d", exp_r.box.x, act_box.x);
            fail_count++;
        end
        if (act_box.y !== exp_r.box.y) begin
            $error("out_y: expected %0d, got %0d", exp_r.box.y, act_box.y);
            fail_count++;
        end
        if (act_box.w !== exp_r.box.w) begin
            $error("out_w: expected %0d, got %0d", exp_r.box.w, act_box.w);
            fail_count++;
        end
        if (act_box.h !== exp_r.box.h) begin
            $error("out_h: expected %0d, got %0d", exp_r.box.h, act_box.h);
            fail_count++;
        end
        if (m_tlast !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, m_tlast);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        result_count = 0;
        match_count = 0;
        new_count = 0;
        drop_count = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NSLOT; s++) begin
                trk_valid[s] = 1'b0;
                trk_used[s] = 1'b0;
            end
            next_id = '0;
            cur_frame = '0;
            age_limit = MAX_AGE_RST;
            iou_thr = IOU_THR_RST;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_MAX_AGE)
                    age_limit = cfg_data;
                else if (cfg_index == REG_IOU_THR)
                    iou_thr = cfg_data[THR_W-1:0];
            end
            // results leave before a new request can produce any in the same edge
            if (m_tvalid && m_tready) begin
                compare_result();
                result_count++;
            end
            if (s_tvalid && s_tready)
                track_request(s_tuser, s_tdata);
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Top of the IoU box tracker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import itrk_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [FUNC_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count, pending_count, result_count, match_count, new_count, drop_count;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int sent_items = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    iou_greedy_box_tracker dut (.*);

    tb_tracker_checker u_checker (.*);

    // receiver: random stalls plus an optional long hold-off
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // valid stays high after the handshake so requests can follow back to back
    task automatic send_request(logic [FUNC_W-1:0] op, logic [31:0] t, box_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {b.h, b.w, b.y, b.x, t};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic box_t rand_box();
        box_t b;
        case ($urandom_range(3))
            0: begin
                b.x = 12'($urandom);
                b.y = 12'($urandom);
                b.w = 12'($urandom);
                b.h = 12'($urandom);
            end
            default: begin
                b.x = 12'($urandom_range(200));
                b.y = 12'($urandom_range(200));
                b.w = 12'($urandom_range(1, 120));
                b.h = 12'($urandom_range(1, 120));
            end
        endcase
        return b;
    endfunction

    function automatic box_t jitter(box_t b);
        box_t j;
        j.x = b.x + 12'($urandom_range(8)) - 12'd4;
        j.y = b.y + 12'($urandom_range(8)) - 12'd4;
        j.w = b.w + 12'($urandom_range(4));
        j.h = b.h + 12'($urandom_range(4));
        return j;
    endfunction

    task automatic random_phase(int nitems, ref logic [31:0] now);
        box_t scene[8];
        int k;
        for (int s = 0; s < 8; s++) scene[s] = rand_box();
        k = 0;
        while (k < nitems) begin
            case ($urandom_range(19))
                0: begin
                    now = now + $urandom_range(5000);
                    send_request(OP_BEGIN, now, rand_box());
                    for (int s = 0; s < 8; s++) scene[s] = jitter(scene[s]);
                end
                1: send_request(OP_REPORT, $urandom, rand_box());
                2: if ($urandom_range(3) == 0) send_request(OP_CLEAR, $urandom, rand_box());
                3, 4: send_request(OP_DETECT, $urandom, rand_box());
                default: send_request(OP_DETECT, $urandom, jitter(scene[$urandom_range(7)]));
            endcase
            k++;
        end
    endtask

    initial begin
        logic [31:0] now;
        box_t b;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty report, detection before any frame, extremes, degenerate box
        send_request(OP_REPORT, 32'd0, '0);
        b = '{h: 12'd10, w: 12'd10, y: 12'd0, x: 12'd0};
        send_request(OP_DETECT, 32'd0, b);
        send_request(OP_DETECT, 32'hFFFF_FFFF, b);
        send_request(OP_DETECT, 32'd0, '{h: 12'hFFF, w: 12'hFFF, y: 12'hFFF, x: 12'hFFF});
        send_request(OP_DETECT, 32'd0, '0);
        send_request(OP_DETECT, 32'd0, '0);
        send_request(OP_BEGIN, 32'd100, '1);
        send_request(OP_DETECT, 32'd0, '{h: 12'd10, w: 12'd10, y: 12'd1, x: 12'd1});
        send_request(OP_REPORT, 32'd0, '0);
        // fill the table, then overflow it
        for (int s = 0; s < 14; s++)
            send_request(OP_DETECT, 32'd0, '{h: 12'd5, w: 12'd5, y: 12'd3000, x: 12'(s * 100)});
        send_request(OP_REPORT, 32'd0, '0);
        send_request(OP_BEGIN, 32'hFFFF_FFF0, '0);
        send_request(OP_CLEAR, 32'd0, '0);
        drain();

        // exercise the extremes of the configuration
        write_reg(REG_MAX_AGE, 16'd100);
        write_reg(REG_IOU_THR, 8'd0);
        now = 32'd0;
        send_idle_pct = 25;
        recv_idle_pct = 63;
        random_phase(150, now);
        drain();

        write_reg(REG_MAX_AGE, 16'hFFFF);
        write_reg(REG_IOU_THR, 8'hFF);
        send_idle_pct = 63;
        recv_idle_pct = 25;
        random_phase(150, now);
        drain();

        write_reg(REG_MAX_AGE, 16'd60000);
        write_reg(REG_IOU_THR, 8'd243);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // long receiver hold-off while reports pile up
        hold_cycles = 600;
        for (int s = 0; s < 10; s++) send_request(OP_REPORT, 32'd0, '0);
        drain();
        write_reg(REG_IOU_THR, 8'd128);
        write_reg(REG_MAX_AGE, 16'd3000);
        random_phase(140, now);
        drain();

        $display("covered %0d requests, %0d results (%0d matched, %0d new, %0d dropped)",
                 sent_items, result_count, match_count, new_count, drop_count);
        $display("four config settings, three idling mixes and a long result stall");
        if (fail_count == 0 && pending_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire
